// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions, reported through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside of reset.
`define PFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop at every rising edge, reset included.
`define PFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, field codes and sizes of the packet-filter program checker.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int MAX_INSNS = 512;
    localparam int MEM_WORDS = 16;

    localparam int IDX_W  = 12;
    localparam int POS_W  = 9;
    localparam int LEN_W  = 12;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [0:0] REG_PROGRAM_LENGTH = 1'b0;

    // instruction class, opcode bits 2:0
    localparam logic [2:0] CLS_LD   = 3'h0;
    localparam logic [2:0] CLS_LDX  = 3'h1;
    localparam logic [2:0] CLS_ST   = 3'h2;
    localparam logic [2:0] CLS_STX  = 3'h3;
    localparam logic [2:0] CLS_ALU  = 3'h4;
    localparam logic [2:0] CLS_JMP  = 3'h5;
    localparam logic [2:0] CLS_RET  = 3'h6;
    localparam logic [2:0] CLS_MISC = 3'h7;

    // operand size, opcode bits 4:3
    localparam logic [1:0] SZ_W = 2'h0;
    localparam logic [1:0] SZ_H = 2'h1;
    localparam logic [1:0] SZ_B = 2'h2;
    localparam logic [1:0] SZ_X = 2'h3;

    // addressing mode, opcode bits 7:5
    localparam logic [2:0] MODE_IMM = 3'h0;
    localparam logic [2:0] MODE_ABS = 3'h1;
    localparam logic [2:0] MODE_IND = 3'h2;
    localparam logic [2:0] MODE_MEM = 3'h3;
    localparam logic [2:0] MODE_LEN = 3'h4;
    localparam logic [2:0] MODE_MSH = 3'h5;

    // alu and jump operation, opcode bits 7:4
    localparam logic [3:0] ALU_ADD = 4'h0;
    localparam logic [3:0] ALU_SUB = 4'h1;
    localparam logic [3:0] ALU_MUL = 4'h2;
    localparam logic [3:0] ALU_DIV = 4'h3;
    localparam logic [3:0] ALU_OR  = 4'h4;
    localparam logic [3:0] ALU_AND = 4'h5;
    localparam logic [3:0] ALU_LSH = 4'h6;
    localparam logic [3:0] ALU_RSH = 4'h7;
    localparam logic [3:0] ALU_NEG = 4'h8;

    localparam logic [3:0] JMP_JA   = 4'h0;
    localparam logic [3:0] JMP_JEQ  = 4'h1;
    localparam logic [3:0] JMP_JGT  = 4'h2;
    localparam logic [3:0] JMP_JGE  = 4'h3;
    localparam logic [3:0] JMP_JSET = 4'h4;

    // ret value source, opcode bits 4:3
    localparam logic [1:0] RVAL_K = 2'h0;
    localparam logic [1:0] RVAL_A = 2'h2;

    // opcode bits 7:3 for store and misc forms
    localparam logic [4:0] HI_ZERO = 5'h00;
    localparam logic [4:0] MISC_TXA = 5'h10;

    localparam logic SRC_K = 1'b0;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] position;
        logic             last;
    } t_pfc_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_pfc_qstat;

endpackage

// ----- hdl/pfc_insn_if.sv -----
// ----------------------------------------------------------------------------
// pfc_insn_if
// Instruction channel: valid/ready with one instruction per transfer.
// ----------------------------------------------------------------------------
interface pfc_insn_if;
    logic        valid;
    logic        ready;
    logic [15:0] opcode;
    logic [7:0]  jump_true;
    logic [7:0]  jump_false;
    logic [31:0] operand_k;

    modport source (output valid, output opcode, output jump_true, output jump_false,
                    output operand_k, input ready);
    modport sink (input valid, input opcode, input jump_true, input jump_false,
                  input operand_k, output ready);
endinterface

// ----- hdl/pfc_result_if.sv -----
// ----------------------------------------------------------------------------
// pfc_result_if
// Result channel: valid/ready with one check result per transfer.
// ----------------------------------------------------------------------------
interface pfc_result_if;
    logic                     valid;
    logic                     ready;
    logic                     instruction_ok;
    logic [pfc_pkg::POS_W-1:0] position;
    logic                     is_last;
    logic                     program_valid;

    modport source (output valid, output instruction_ok, output position, output is_last,
                    output program_valid, input ready);
    modport sink (input valid, input instruction_ok, input position, input is_last,
                  input program_valid, output ready);
endinterface

// ----- hdl/pfc_queue.sv -----
// ----------------------------------------------------------------------------
// pfc_queue
// Two-entry queue between the decode front and the verdict back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pfc_pkg::t_pfc_entry i_data,
    input  logic                i_pop,
    output pfc_pkg::t_pfc_entry o_data,
    output pfc_pkg::t_pfc_qstat o_stat
);

    pfc_pkg::t_pfc_entry r_mem [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;
    logic [1:0]          n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count == 2'd2;
    assign o_stat.empty = r_count == 2'd0;

    `PFC_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_stat.full), "push into full queue")
    `PFC_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_stat.empty), "pop from empty queue")
    `PFC_ASSERT(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> r_count == $past(r_count) + 2'd1, "count lost a push")

endmodule

// ----- hdl/pfc_front.sv -----
// ----------------------------------------------------------------------------
// pfc_front
// Instruction decode: field checks, jump bounds, position and last flag.
// ----------------------------------------------------------------------------
module pfc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [pfc_pkg::LEN_W-1:0]       i_program_length,
    pfc_insn_if.sink                        i_insn,
    input  pfc_pkg::t_pfc_qstat             i_qstat,
    output logic                            o_push,
    output pfc_pkg::t_pfc_entry             o_entry
);

    logic [pfc_pkg::IDX_W-1:0] r_idx;
    logic [pfc_pkg::IDX_W-1:0] n_idx;
    logic [pfc_pkg::LEN_W-1:0] remaining;
    logic [7:0]                c;
    logic [2:0]                cls;
    logic [2:0]                mode;
    logic [1:0]                sz;
    logic [3:0]                op;
    logic                      mem_ok;
    logic                      len_ok;
    logic                      in_range;
    logic                      last;
    logic                      check;
    logic                      ok;

    assign c    = i_insn.opcode[7:0];
    assign cls  = c[2:0];
    assign sz   = c[4:3];
    assign mode = c[7:5];
    assign op   = c[7:4];

    assign len_ok    = (i_program_length != '0)
                    && ({1'b0, i_program_length} <= 13'(pfc_pkg::MAX_INSNS));
    assign in_range  = r_idx < i_program_length;
    assign remaining = i_program_length - r_idx - 12'd1;
    assign mem_ok    = i_insn.operand_k < 32'(pfc_pkg::MEM_WORDS);

    always_comb begin
        check = 1'b0;
        unique case (cls)
            pfc_pkg::CLS_LD: begin
                unique case (mode) inside
                    pfc_pkg::MODE_ABS, pfc_pkg::MODE_IND: check = sz != pfc_pkg::SZ_X;
                    pfc_pkg::MODE_IMM, pfc_pkg::MODE_LEN: check = sz == pfc_pkg::SZ_W;
                    pfc_pkg::MODE_MEM: check = (sz == pfc_pkg::SZ_W) && mem_ok;
                    default: check = 1'b0;
                endcase
            end
            pfc_pkg::CLS_LDX: begin
                unique case (mode) inside
                    pfc_pkg::MODE_IMM, pfc_pkg::MODE_LEN: check = sz == pfc_pkg::SZ_W;
                    pfc_pkg::MODE_MEM: check = (sz == pfc_pkg::SZ_W) && mem_ok;
                    pfc_pkg::MODE_MSH: check = sz == pfc_pkg::SZ_B;
                    default: check = 1'b0;
                endcase
            end
            pfc_pkg::CLS_ST, pfc_pkg::CLS_STX: begin
                check = (c[7:3] == pfc_pkg::HI_ZERO) && mem_ok;
            end
            pfc_pkg::CLS_ALU: begin
                unique case (op) inside
                    pfc_pkg::ALU_ADD, pfc_pkg::ALU_SUB, pfc_pkg::ALU_MUL,
                    pfc_pkg::ALU_OR, pfc_pkg::ALU_AND, pfc_pkg::ALU_LSH,
                    pfc_pkg::ALU_RSH, pfc_pkg::ALU_NEG: check = 1'b1;
                    pfc_pkg::ALU_DIV: check = !((c[3] == pfc_pkg::SRC_K)
                                             && (i_insn.operand_k == '0));
                    default: check = 1'b0;
                endcase
            end
            pfc_pkg::CLS_JMP: begin
                unique case (op) inside
                    pfc_pkg::JMP_JA: check = i_insn.operand_k < 32'(remaining);
                    pfc_pkg::JMP_JEQ, pfc_pkg::JMP_JGT, pfc_pkg::JMP_JGE,
                    pfc_pkg::JMP_JSET: check = (12'(i_insn.jump_true) < remaining)
                                            && (12'(i_insn.jump_false) < remaining);
                    default: check = 1'b0;
                endcase
            end
            pfc_pkg::CLS_RET: begin
                check = (sz == pfc_pkg::RVAL_K) || (sz == pfc_pkg::RVAL_A);
            end
            default: begin
                check = (c[7:3] == pfc_pkg::HI_ZERO) || (c[7:3] == pfc_pkg::MISC_TXA);
            end
        endcase
    end

    always_comb begin
        last = len_ok && (!in_range || (r_idx == i_program_length - 12'd1));
        ok   = len_ok && in_range && check && (!last || (cls == pfc_pkg::CLS_RET));
        n_idx = last ? '0 : r_idx + 12'd1;
    end

    assign i_insn.ready     = !i_qstat.full;
    assign o_push           = i_insn.valid && !i_qstat.full;
    assign o_entry.ok       = ok;
    assign o_entry.position = r_idx[pfc_pkg::POS_W-1:0];
    assign o_entry.last     = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (o_push) begin
            r_idx <= n_idx;
        end
    end

endmodule

// ----- hdl/pfc_back.sv -----
// ----------------------------------------------------------------------------
// pfc_back
// Verdict stage: sticky error flag and the registered result output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfc_pkg::t_pfc_entry i_entry,
    input  pfc_pkg::t_pfc_qstat i_qstat,
    output logic                o_pop,
    pfc_result_if.source        o_res
);

    logic                      r_err;
    logic                      r_valid;
    logic                      r_ok;
    logic [pfc_pkg::POS_W-1:0] r_position;
    logic                      r_last;
    logic                      r_program_valid;

    assign o_pop = !i_qstat.empty && (!r_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                if (i_entry.last) begin
                    r_err <= 1'b0;
                end else if (!i_entry.ok) begin
                    r_err <= 1'b1;
                end
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ok            <= i_entry.ok;
            r_position      <= i_entry.position;
            r_last          <= i_entry.last;
            r_program_valid <= i_entry.last && i_entry.ok && !r_err;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.instruction_ok = r_ok;
    assign o_res.position       = r_position;
    assign o_res.is_last        = r_last;
    assign o_res.program_valid  = r_program_valid;

    `PFC_ASSERT(a_verdict_on_last, i_clk, i_rst_n, r_valid |-> (!r_program_valid || (r_last && r_ok)), "verdict without passing last instruction")
    `PFC_ASSERT(a_rearm, i_clk, i_rst_n, (o_pop && i_entry.last) |=> !r_err, "error flag kept past program end")
    `PFC_ASSERT(a_sticky, i_clk, i_rst_n, (o_pop && !i_entry.last && !i_entry.ok) |=> r_err, "failed instruction not recorded")

endmodule

// ----- hdl/packet_filter_program_checker.sv -----
// ----------------------------------------------------------------------------
// packet_filter_program_checker
// Checks a classic packet-filter program one instruction per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Write program_length over the APB port (byte address 0) while idle.
//   Stream the program on i_insn, one instruction per transfer; every
//   instruction gives one transfer on o_res with its pass flag and position.
//   The final instruction carries is_last and the program verdict, after
//   which the checker rearms for the next program.
// Pipeline and throughput:
//   A result is registered in the queue and then in the output register;
//   one instruction per cycle is sustained while o_res accepts results.
//   Decode is combinational, and a two-entry queue feeds the output register.
// Reset:
//   Synchronous, active low. Clears the length, the position counter, the
//   error flag, the queue and the output valid.
// Stall:
//   When o_res is held off the output register keeps its result, the queue
//   fills, and i_insn.ready drops once both queue entries are taken.
// ----------------------------------------------------------------------------
module packet_filter_program_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pfc_pkg::ADDR_W-1:0] paddr,
    input  logic [pfc_pkg::DATA_W-1:0] pwdata,
    output logic [pfc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    pfc_insn_if.sink                   i_insn,
    pfc_result_if.source               o_res
);

    logic [pfc_pkg::LEN_W-1:0] r_program_length;
    logic                      reg_write;
    logic                      push;
    logic                      pop;
    pfc_pkg::t_pfc_entry       push_entry;
    pfc_pkg::t_pfc_entry       pop_entry;
    pfc_pkg::t_pfc_qstat       qstat;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite
                    && (paddr[pfc_pkg::ADDR_W-1 -: 1] == pfc_pkg::REG_PROGRAM_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_program_length <= '0;
        end else if (reg_write) begin
            r_program_length <= pwdata[pfc_pkg::LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[pfc_pkg::ADDR_W-1 -: 1] == pfc_pkg::REG_PROGRAM_LENGTH) begin
            prdata = {{(pfc_pkg::DATA_W-pfc_pkg::LEN_W){1'b0}}, r_program_length};
        end
    end

    pfc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_program_length (r_program_length),
        .i_insn           (i_insn),
        .i_qstat          (qstat),
        .o_push           (push),
        .o_entry          (push_entry)
    );

    pfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (pop_entry),
        .o_stat  (qstat)
    );

    pfc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (pop_entry),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ----- tb/packet_filter_program_checker_tb.sv -----
// ----------------------------------------------------------------------------
// packet_filter_program_checker_tb
// Self-checking bench for the packet-filter program checker. A scoreboard
// class tracks the program length, instruction index and sticky error flag,
// predicts each instruction verdict on every input transfer, and compares
// every result transfer in order. A short directed program set covers each
// instruction class, the bad-length and past-the-end cases; random programs
// follow under three idling profiles.
// ----------------------------------------------------------------------------
module packet_filter_program_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] opcode;
        logic [7:0]  jt;
        logic [7:0]  jf;
        logic [31:0] k;
    } t_insn;

    typedef struct packed {
        logic                      ok;
        logic [pfc_pkg::POS_W-1:0] position;
        logic                      last;
        logic                      verdict;
    } t_verdict;

    class t_verdict_board;
        logic [pfc_pkg::LEN_W-1:0] length;
        logic [pfc_pkg::IDX_W-1:0] index;
        bit                        error_seen;
        t_verdict                  pending[$];
        int unsigned               failures;
        int unsigned               reported;

        function new();
            length     = '0;
            index      = '0;
            error_seen = 1'b0;
            failures   = 0;
            reported   = 0;
        endfunction

        function void set_length(logic [pfc_pkg::LEN_W-1:0] value);
            length = value;
        endfunction

        function bit length_ok();
            return length != 0 && length <= pfc_pkg::MAX_INSNS;
        endfunction

        function int unsigned remaining();
            if (!length_ok() || index >= length) begin
                return 0;
            end
            return length - index - 1;
        endfunction

        function bit closing();
            return length_ok() && (index + 1 >= length);
        endfunction

        static function bit insn_legal(logic [7:0] c, logic [7:0] jt, logic [7:0] jf,
                                       logic [31:0] k, int unsigned rem);
            logic [2:0] mode;
            logic [1:0] sz;
            logic [3:0] op;
            bit         mem;
            mode = c[7:5];
            sz   = c[4:3];
            op   = c[7:4];
            mem  = k < pfc_pkg::MEM_WORDS;
            case (c[2:0])
                pfc_pkg::CLS_LD: begin
                    if (mode == pfc_pkg::MODE_ABS || mode == pfc_pkg::MODE_IND)
                        return sz != pfc_pkg::SZ_X;
                    if (mode == pfc_pkg::MODE_IMM || mode == pfc_pkg::MODE_LEN)
                        return sz == pfc_pkg::SZ_W;
                    if (mode == pfc_pkg::MODE_MEM) return sz == pfc_pkg::SZ_W && mem;
                    return 1'b0;
                end
                pfc_pkg::CLS_LDX: begin
                    if (mode == pfc_pkg::MODE_IMM || mode == pfc_pkg::MODE_LEN)
                        return sz == pfc_pkg::SZ_W;
                    if (mode == pfc_pkg::MODE_MEM) return sz == pfc_pkg::SZ_W && mem;
                    if (mode == pfc_pkg::MODE_MSH) return sz == pfc_pkg::SZ_B;
                    return 1'b0;
                end
                pfc_pkg::CLS_ST, pfc_pkg::CLS_STX: begin
                    return c[7:3] == pfc_pkg::HI_ZERO && mem;
                end
                pfc_pkg::CLS_ALU: begin
                    if (op <= pfc_pkg::ALU_MUL ||
                        (op >= pfc_pkg::ALU_OR && op <= pfc_pkg::ALU_NEG)) return 1'b1;
                    if (op == pfc_pkg::ALU_DIV) return !(c[3] == pfc_pkg::SRC_K && k == 0);
                    return 1'b0;
                end
                pfc_pkg::CLS_JMP: begin
                    if (op == pfc_pkg::JMP_JA) return k < rem;
                    if (op >= pfc_pkg::JMP_JEQ && op <= pfc_pkg::JMP_JSET)
                        return jt < rem && jf < rem;
                    return 1'b0;
                end
                pfc_pkg::CLS_RET: begin
                    return sz == pfc_pkg::RVAL_K || sz == pfc_pkg::RVAL_A;
                end
                default: begin
                    return c[7:3] == pfc_pkg::HI_ZERO || c[7:3] == pfc_pkg::MISC_TXA;
                end
            endcase
        endfunction

        function void note_instruction(t_insn insn);
            t_verdict v;
            v = '0;
            v.position = index[pfc_pkg::POS_W-1:0];
            if (length_ok()) begin
                if (index < length) begin
                    v.ok   = insn_legal(insn.opcode[7:0], insn.jt, insn.jf, insn.k,
                                        length - index - 1);
                    v.last = (index == length - 1);
                    if (v.last && insn.opcode[2:0] != pfc_pkg::CLS_RET) v.ok = 1'b0;
                end else begin
                    v.last = 1'b1;
                end
            end
            if (v.last) begin
                v.verdict  = v.ok && !error_seen;
                index      = '0;
                error_seen = 1'b0;
            end else begin
                index = index + 1'b1;
                if (!v.ok) error_seen = 1'b1;
            end
            pending.push_back(v);
        endfunction

        function void check_result(t_verdict got);
            t_verdict want;
            if (pending.size() == 0) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected result: ok=%0b pos=%0d last=%0b verdict=%0b",
                             got.ok, got.position, got.last, got.verdict);
                end
                return;
            end
            want = pending.pop_front();
            if (got.ok !== want.ok || got.position !== want.position ||
                got.last !== want.last || got.verdict !== want.verdict) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("mismatch at %0t: exp ok=%0b pos=%0d last=%0b verdict=%0b",
                             $realtime, want.ok, want.position, want.last, want.verdict);
                    $display("                 got ok=%0b pos=%0d last=%0b verdict=%0b",
                             got.ok, got.position, got.last, got.verdict);
                end
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [pfc_pkg::ADDR_W-1:0] paddr;
    logic [pfc_pkg::DATA_W-1:0] pwdata;
    logic [pfc_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    pfc_insn_if   insn_bus ();
    pfc_result_if res_bus ();

    packet_filter_program_checker u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_insn  (insn_bus),
        .o_res   (res_bus)
    );

    t_verdict_board board = new();
    int unsigned    tx_idle_pct;
    int unsigned    rx_idle_pct;

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        res_bus.ready = (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            board.check_result({res_bus.instruction_ok, res_bus.position,
                                res_bus.is_last, res_bus.program_valid});
        end
    end

    initial begin
        #2_000_000;
        $display("packet_filter_program_checker verification failed");
        $finish;
    end

    function automatic t_insn mk(logic [15:0] opcode, logic [7:0] jt, logic [7:0] jf,
                                 logic [31:0] k);
        return '{opcode: opcode, jt: jt, jf: jf, k: k};
    endfunction

    function automatic t_insn compose_instruction(int unsigned rem, bit closing);
        t_insn       insn;
        logic [2:0]  cls;
        logic [2:0]  mode;
        logic [1:0]  sz;
        int unsigned cap;
        insn.opcode = 16'($urandom);
        insn.jt     = 8'($urandom);
        insn.jf     = 8'($urandom);
        insn.k      = $urandom;
        if ($urandom_range(0, 99) < 5) return insn;
        cap  = (rem > 256) ? 255 : ((rem == 0) ? 0 : rem - 1);
        cls  = (closing && $urandom_range(0, 9) != 0) ? pfc_pkg::CLS_RET
                                                       : 3'($urandom_range(0, 7));
        mode = 3'($urandom);
        sz   = 2'($urandom);
        case (cls)
            pfc_pkg::CLS_LD: begin
                case ($urandom_range(0, 4))
                    0: mode = pfc_pkg::MODE_IMM;
                    1: mode = pfc_pkg::MODE_ABS;
                    2: mode = pfc_pkg::MODE_IND;
                    3: mode = pfc_pkg::MODE_MEM;
                    default: mode = pfc_pkg::MODE_LEN;
                endcase
                if (mode == pfc_pkg::MODE_ABS || mode == pfc_pkg::MODE_IND) begin
                    sz = 2'($urandom_range(pfc_pkg::SZ_W, pfc_pkg::SZ_B));
                end else begin
                    sz = pfc_pkg::SZ_W;
                end
                if (mode == pfc_pkg::MODE_MEM && $urandom_range(0, 9) != 0) begin
                    insn.k = $urandom_range(0, pfc_pkg::MEM_WORDS - 1);
                end
                insn.opcode[7:0] = {mode, sz, pfc_pkg::CLS_LD};
            end
            pfc_pkg::CLS_LDX: begin
                case ($urandom_range(0, 3))
                    0: mode = pfc_pkg::MODE_IMM;
                    1: mode = pfc_pkg::MODE_MEM;
                    2: mode = pfc_pkg::MODE_LEN;
                    default: mode = pfc_pkg::MODE_MSH;
                endcase
                sz = (mode == pfc_pkg::MODE_MSH) ? pfc_pkg::SZ_B : pfc_pkg::SZ_W;
                if (mode == pfc_pkg::MODE_MEM && $urandom_range(0, 9) != 0) begin
                    insn.k = $urandom_range(0, pfc_pkg::MEM_WORDS - 1);
                end
                insn.opcode[7:0] = {mode, sz, pfc_pkg::CLS_LDX};
            end
            pfc_pkg::CLS_ST, pfc_pkg::CLS_STX: begin
                if ($urandom_range(0, 9) != 0) insn.k = $urandom_range(0, pfc_pkg::MEM_WORDS);
                insn.opcode[7:0] = {pfc_pkg::HI_ZERO, cls};
            end
            pfc_pkg::CLS_ALU: begin
                insn.opcode[7:0] = {4'($urandom_range(pfc_pkg::ALU_ADD, pfc_pkg::ALU_NEG)),
                                    1'($urandom), pfc_pkg::CLS_ALU};
                if (insn.opcode[7:4] == pfc_pkg::ALU_DIV && $urandom_range(0, 2) == 0)
                    insn.k = '0;
            end
            pfc_pkg::CLS_JMP: begin
                insn.opcode[7:0] = {4'($urandom_range(pfc_pkg::JMP_JA, pfc_pkg::JMP_JSET)),
                                    1'($urandom), pfc_pkg::CLS_JMP};
                if (rem != 0 && $urandom_range(0, 9) != 0) begin
                    insn.jt = 8'($urandom_range(0, cap));
                    insn.jf = 8'($urandom_range(0, cap));
                    insn.k  = $urandom_range(0, cap);
                end
            end
            pfc_pkg::CLS_RET: begin
                sz = ($urandom_range(0, 9) == 0) ? 2'($urandom) :
                     ($urandom_range(0, 1) ? pfc_pkg::RVAL_A : pfc_pkg::RVAL_K);
                insn.opcode[7:0] = {mode, sz, pfc_pkg::CLS_RET};
            end
            default: begin
                insn.opcode[7:0] = {($urandom_range(0, 1) ? pfc_pkg::MISC_TXA
                                                           : pfc_pkg::HI_ZERO),
                                    pfc_pkg::CLS_MISC};
            end
        endcase
        return insn;
    endfunction

    task automatic hold_instructions();
        @(negedge i_clk);
        insn_bus.valid = 1'b0;
    endtask

    task automatic send_instruction(t_insn insn);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            insn_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        insn_bus.valid      = 1'b1;
        insn_bus.opcode     = insn.opcode;
        insn_bus.jump_true  = insn.jt;
        insn_bus.jump_false = insn.jf;
        insn_bus.operand_k  = insn.k;
        do @(posedge i_clk); while (!insn_bus.ready);
        board.note_instruction(insn);
    endtask

    task automatic write_length(logic [pfc_pkg::LEN_W-1:0] value);
        hold_instructions();
        while (board.pending.size() != 0) @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {pfc_pkg::REG_PROGRAM_LENGTH, 2'b00};
        pwdata  = pfc_pkg::DATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_length(value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_program(int unsigned count);
        repeat (count) send_instruction(compose_instruction(board.remaining(),
                                                            board.closing()));
    endtask

    initial begin
        int unsigned               sent;
        int unsigned               count;
        int unsigned               pick;
        logic [pfc_pkg::LEN_W-1:0] len;
        bit                        long_done;

        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        insn_bus.valid      = 1'b0;
        insn_bus.opcode     = '0;
        insn_bus.jump_true  = '0;
        insn_bus.jump_false = '0;
        insn_bus.operand_k  = '0;
        res_bus.ready       = 1'b0;
        tx_idle_pct         = 34;
        rx_idle_pct         = 71;
        long_done           = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // mixed program with a zero constant divisor
        write_length(5);
        send_instruction(mk({8'h00, pfc_pkg::MODE_ABS, pfc_pkg::SZ_W, pfc_pkg::CLS_LD},
                            8'h00, 8'h00, $urandom));
        send_instruction(mk({8'h5a, pfc_pkg::MODE_MSH, pfc_pkg::SZ_B, pfc_pkg::CLS_LDX},
                            8'h00, 8'h00, 32'h1));
        send_instruction(mk({8'h00, pfc_pkg::ALU_DIV, pfc_pkg::SRC_K, pfc_pkg::CLS_ALU},
                            8'h00, 8'h00, 32'h0));
        send_instruction(mk({8'h00, pfc_pkg::JMP_JEQ, 1'b0, pfc_pkg::CLS_JMP},
                            8'd1, 8'd0, 32'h0));
        send_instruction(mk({8'h00, 3'b000, pfc_pkg::RVAL_K, pfc_pkg::CLS_RET},
                            8'h00, 8'h00, 32'hffff));

        // single clean program
        write_length(1);
        send_instruction(mk({8'h00, 3'b000, pfc_pkg::RVAL_A, pfc_pkg::CLS_RET},
                            8'h00, 8'h00, 32'h0));

        // memory bounds, misc forms, jump overrun, non-ret last
        write_length(6);
        send_instruction(mk({8'h00, pfc_pkg::MODE_MEM, pfc_pkg::SZ_W, pfc_pkg::CLS_LD},
                            8'h00, 8'h00, 32'(pfc_pkg::MEM_WORDS - 1)));
        send_instruction(mk({8'h00, pfc_pkg::HI_ZERO, pfc_pkg::CLS_ST},
                            8'h00, 8'h00, 32'h0));
        send_instruction(mk({8'h00, pfc_pkg::HI_ZERO, pfc_pkg::CLS_STX},
                            8'h00, 8'h00, 32'(pfc_pkg::MEM_WORDS)));
        send_instruction(mk({8'h00, pfc_pkg::ALU_NEG, 1'b1, pfc_pkg::CLS_ALU},
                            8'h00, 8'h00, 32'h0));
        send_instruction(mk({8'h00, pfc_pkg::JMP_JA, 1'b0, pfc_pkg::CLS_JMP},
                            8'h00, 8'h00, 32'd1));
        send_instruction(mk({8'h00, pfc_pkg::MISC_TXA, pfc_pkg::CLS_MISC},
                            8'h00, 8'h00, 32'h0));

        // bad lengths: every instruction flagged, index counts on
        write_length(0);
        send_instruction(mk(16'h0000, 8'h00, 8'h00, 32'h0));
        send_instruction(mk({8'h00, pfc_pkg::HI_ZERO, pfc_pkg::CLS_MISC},
                            8'h00, 8'h00, 32'h0));
        write_length(12'd4095);
        send_instruction(mk(16'hffff, 8'hff, 8'hff, 32'hffff_ffff));
        write_length(pfc_pkg::LEN_W'(pfc_pkg::MAX_INSNS + 1));
        send_instruction(mk({8'h00, 3'b000, pfc_pkg::RVAL_K, pfc_pkg::CLS_RET},
                            8'h00, 8'h00, 32'h0));

        // index already past the new length
        write_length(2);
        send_instruction(mk({8'h00, 3'b000, pfc_pkg::RVAL_K, pfc_pkg::CLS_RET},
                            8'h00, 8'h00, 32'h0));
        send_instruction(mk({8'h00, pfc_pkg::MODE_IMM, pfc_pkg::SZ_H, pfc_pkg::CLS_LD},
                            8'h00, 8'h00, 32'h0));
        send_instruction(mk({8'hff, 3'b000, pfc_pkg::SZ_X, pfc_pkg::CLS_RET},
                            8'h00, 8'h00, 32'h0));

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 34 : ((ph == 1) ? 71 : 0);
            rx_idle_pct = (ph == 0) ? 71 : ((ph == 1) ? 34 : 0);
            sent = 0;
            while (sent < 260) begin
                pick = $urandom_range(0, 99);
                if (ph == 2 && !long_done) begin
                    len       = pfc_pkg::LEN_W'(pfc_pkg::MAX_INSNS);
                    long_done = 1'b1;
                end else if (pick < 4) begin
                    len = 0;
                end else if (pick < 10) begin
                    len = pfc_pkg::LEN_W'($urandom_range(pfc_pkg::MAX_INSNS + 1, 4095));
                end else if (pick < 18) begin
                    len = 1;
                end else begin
                    len = pfc_pkg::LEN_W'($urandom_range(2, 12));
                end
                write_length(len);
                count = (len == 0 || len > pfc_pkg::MAX_INSNS) ? $urandom_range(1, 4)
                                                              : 32'(len);
                if ($urandom_range(0, 9) == 0) count = $urandom_range(1, count);
                send_program(count);
                sent += count;
            end
        end

        hold_instructions();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.failures == 0 && board.pending.size() == 0) begin
            $display("packet_filter_program_checker verification clean");
        end else begin
            $display("packet_filter_program_checker verification failed");
        end
        $finish;
    end
endmodule
